// File: design/midpoint_circle_rasterizer_top_assert.svh
// Assertion macros shared by the rasterizer RTL.
`ifndef MIDPOINT_CIRCLE_RASTERIZER_TOP_ASSERT_SVH
`define MIDPOINT_CIRCLE_RASTERIZER_TOP_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define MCR_ASSERT_IMPL(label, clk_s, rst_s, ante, cons) \
    label: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
        else $error("midpoint circle rasterizer: implication check failed");

// Next-cycle implication, checked out of reset.
`define MCR_ASSERT_NEXT(label, clk_s, rst_s, ante, cons) \
    label: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) \
        else $error("midpoint circle rasterizer: next-cycle check failed");

`endif

// File: design/mcr_pkg.sv
// Shared types and constants of the midpoint circle rasterizer.
package mcr_pkg;

    localparam logic OP_START = 1'b0;
    localparam logic OP_STEP  = 1'b1;

    localparam int QDEPTH   = 2;
    localparam int QPTR_W   = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int QCNT_W   = $clog2(QDEPTH + 1);
    localparam int PT_CNT_W = 3;

    typedef struct packed {
        logic signed [14:0] cx;
        logic signed [14:0] cy;
        logic signed [14:0] x;
        logic signed [14:0] y;
        logic               fin;
    } job_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

endpackage

// File: design/midpoint_circle_rasterizer_top.sv
// Midpoint circle rasterizer top level: front end, job queue and point sequencer.
// A start request (op 0) loads center and radius and gives no pixels; a step
// request (op 1) on a running circle queues one octant job and yields eight pixels, one per
// cycle while out_ready does not stall the output, drained by the point sequencer from the
// two-entry job queue. The front end keeps taking requests while the queue has room. The
// final pixel of a circle carries last; a zero radius gives an empty circle.
`include "midpoint_circle_rasterizer_top_assert.svh"

module midpoint_circle_rasterizer_top import mcr_pkg::*; (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic               op,
    input  logic signed [14:0] center_x,
    input  logic signed [14:0] center_y,
    input  logic        [13:0] radius,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [15:0] point_x,
    output logic signed [15:0] point_y,
    output logic               last
);

    q_stat_t q_stat;
    logic    push;
    logic    pop;
    job_t    wr_job;
    job_t    rd_job;

    mcr_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .op       (op),
        .center_x (center_x),
        .center_y (center_y),
        .radius   (radius),
        .q_stat   (q_stat),
        .push     (push),
        .job      (wr_job)
    );

    mcr_queue u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .wr_job (wr_job),
        .pop    (pop),
        .rd_job (rd_job),
        .q_stat (q_stat)
    );

    mcr_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_job     (rd_job),
        .q_stat    (q_stat),
        .pop       (pop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .point_x   (point_x),
        .point_y   (point_y),
        .last      (last)
    );

    `MCR_ASSERT_IMPL(a_no_push_full, clk, rst_n, push, !q_stat.full)
    `MCR_ASSERT_IMPL(a_no_pop_empty, clk, rst_n, pop, !q_stat.empty)
    `MCR_ASSERT_IMPL(a_start_no_job, clk, rst_n, in_valid && in_ready && (op == OP_START), !push)
    `MCR_ASSERT_NEXT(a_push_fills, clk, rst_n, push && !pop, !q_stat.empty)

endmodule

// File: design/mcr_front.sv
// Front end: accepts requests, runs the midpoint error recurrence, queues octant jobs.
module mcr_front import mcr_pkg::*; (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic               op,
    input  logic signed [14:0] center_x,
    input  logic signed [14:0] center_y,
    input  logic        [13:0] radius,
    input  q_stat_t            q_stat,
    output logic               push,
    output job_t               job
);

    logic               busy_reg,  busy_next;
    logic signed [14:0] cx_reg,    cx_next;
    logic signed [14:0] cy_reg,    cy_next;
    logic signed [14:0] sx_reg,    sx_next;
    logic signed [14:0] sy_reg,    sy_next;
    logic        [15:0] xinc_reg,  xinc_next;
    logic        [15:0] yinc_reg,  yinc_next;
    logic signed [17:0] err_reg,   err_next;
    logic        [15:0] tr_reg,    tr_next;

    logic               accept;
    logic signed [17:0] e1;
    logic signed [14:0] y1;
    logic        [15:0] yinc1;
    logic signed [14:0] x2;
    logic        [15:0] xinc2;
    logic signed [17:0] e2;
    logic               fin;

    assign in_ready = !q_stat.full;
    assign accept   = in_valid && in_ready;
    assign push     = accept && (op == OP_STEP) && busy_reg;

    always_comb
    begin
        e1    = err_reg;
        y1    = sy_reg;
        yinc1 = yinc_reg;
        if (err_reg <= 18'sd0)
        begin
            y1    = sy_reg + 15'sd1;
            e1    = err_reg + $signed({2'b00, yinc_reg});
            yinc1 = yinc_reg + 16'd2;
        end
        x2    = sx_reg;
        xinc2 = xinc_reg;
        e2    = e1;
        if (e1 > 18'sd0)
        begin
            x2    = sx_reg - 15'sd1;
            xinc2 = xinc_reg + 16'd2;
            e2    = e1 + $signed({2'b00, xinc2}) - $signed({2'b00, tr_reg});
        end
        fin = (x2 < y1);
    end

    assign job = '{cx: cx_reg, cy: cy_reg, x: sx_reg, y: sy_reg, fin: fin};

    always_comb
    begin
        busy_next = busy_reg;
        cx_next   = cx_reg;
        cy_next   = cy_reg;
        sx_next   = sx_reg;
        sy_next   = sy_reg;
        xinc_next = xinc_reg;
        yinc_next = yinc_reg;
        err_next  = err_reg;
        tr_next   = tr_reg;
        if (accept && (op == OP_START))
        begin
            cx_next   = center_x;
            cy_next   = center_y;
            tr_next   = {1'b0, radius, 1'b0};
            sx_next   = $signed({1'b0, radius}) - 15'sd1;
            sy_next   = '0;
            xinc_next = 16'd1;
            yinc_next = 16'd1;
            err_next  = 18'sd1 - $signed({3'b000, radius, 1'b0});
            busy_next = (radius != '0);
        end
        else if (push)
        begin
            sx_next   = x2;
            sy_next   = y1;
            xinc_next = xinc2;
            yinc_next = yinc1;
            err_next  = e2;
            busy_next = !fin;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cx_reg   <= '0;
            cy_reg   <= '0;
            sx_reg   <= '0;
            sy_reg   <= '0;
            xinc_reg <= 16'd1;
            yinc_reg <= 16'd1;
            err_reg  <= '0;
            tr_reg   <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cx_reg   <= cx_next;
            cy_reg   <= cy_next;
            sx_reg   <= sx_next;
            sy_reg   <= sy_next;
            xinc_reg <= xinc_next;
            yinc_reg <= yinc_next;
            err_reg  <= err_next;
            tr_reg   <= tr_next;
        end
    end

endmodule

// File: design/mcr_queue.sv
// Short job queue between the front end and the point sequencer.
module mcr_queue import mcr_pkg::*; (
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push,
    input  job_t    wr_job,
    input  logic    pop,
    output job_t    rd_job,
    output q_stat_t q_stat
);

    job_t              mem [QDEPTH];
    logic [QPTR_W-1:0] wp_reg,  wp_next;
    logic [QPTR_W-1:0] rp_reg,  rp_next;
    logic [QCNT_W-1:0] cnt_reg, cnt_next;

    assign q_stat.full  = (cnt_reg == QCNT_W'(QDEPTH));
    assign q_stat.empty = (cnt_reg == '0);
    assign rd_job       = mem[rp_reg];

    always_comb
    begin
        wp_next  = wp_reg;
        rp_next  = rp_reg;
        cnt_next = cnt_reg;
        if (push)
        begin
            wp_next = (wp_reg == QPTR_W'(QDEPTH - 1)) ? '0 : wp_reg + 1'b1;
        end
        if (pop)
        begin
            rp_next = (rp_reg == QPTR_W'(QDEPTH - 1)) ? '0 : rp_reg + 1'b1;
        end
        if (push && !pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wp_reg] <= wr_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

endmodule

// File: design/mcr_back.sv
// Point sequencer: expands one octant job into eight mirrored pixels.
module mcr_back import mcr_pkg::*; (
    input  logic               clk,
    input  logic               rst_n,
    input  job_t               q_job,
    input  q_stat_t            q_stat,
    output logic               pop,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [15:0] point_x,
    output logic signed [15:0] point_y,
    output logic               last
);

    job_t                job_reg;
    logic                jv_reg,  jv_next;
    logic [PT_CNT_W-1:0] idx_reg, idx_next;
    logic                ov_reg,  ov_next;
    logic signed [15:0]  px_reg;
    logic signed [15:0]  py_reg;
    logic                last_reg;

    logic                advance;
    logic                job_done;
    logic signed [15:0]  ox;
    logic signed [15:0]  oy;
    logic signed [15:0]  px;
    logic signed [15:0]  py;

    assign advance  = jv_reg && (!ov_reg || out_ready);
    assign job_done = advance && (idx_reg == '1);
    assign pop      = !q_stat.empty && (!jv_reg || job_done);

    always_comb
    begin
        if (idx_reg[2])
        begin
            ox = 16'(job_reg.y);
            oy = 16'(job_reg.x);
        end
        else
        begin
            ox = 16'(job_reg.x);
            oy = 16'(job_reg.y);
        end
        px = idx_reg[1] ? 16'(job_reg.cx) - ox : 16'(job_reg.cx) + ox;
        py = idx_reg[0] ? 16'(job_reg.cy) + oy : 16'(job_reg.cy) - oy;
    end

    always_comb
    begin
        jv_next  = jv_reg;
        idx_next = idx_reg;
        ov_next  = ov_reg;
        if (out_ready)
        begin
            ov_next = 1'b0;
        end
        if (advance)
        begin
            ov_next  = 1'b1;
            idx_next = idx_reg + 1'b1;
        end
        if (job_done)
        begin
            jv_next = 1'b0;
        end
        if (pop)
        begin
            jv_next  = 1'b1;
            idx_next = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            job_reg <= q_job;
        end
        if (advance)
        begin
            px_reg   <= px;
            py_reg   <= py;
            last_reg <= job_reg.fin && (idx_reg == '1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            jv_reg  <= 1'b0;
            idx_reg <= '0;
            ov_reg  <= 1'b0;
        end
        else
        begin
            jv_reg  <= jv_next;
            idx_reg <= idx_next;
            ov_reg  <= ov_next;
        end
    end

    assign out_valid = ov_reg;
    assign point_x   = px_reg;
    assign point_y   = py_reg;
    assign last      = last_reg;

endmodule

// File: tb/sv/mcr_circle_checker.sv
// Pixel predictor and scoreboard for the midpoint circle rasterizer channels.
module mcr_circle_checker
    import mcr_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               in_ready,
    input  logic               op,
    input  logic signed [14:0] center_x,
    input  logic signed [14:0] center_y,
    input  logic        [13:0] radius,
    input  logic               out_valid,
    input  logic               out_ready,
    input  logic signed [15:0] point_x,
    input  logic signed [15:0] point_y,
    input  logic               last,
    output int                 fail_count,
    output int                 pixels_pending,
    output int                 pixels_checked
);

    typedef struct {
        logic signed [15:0] px;
        logic signed [15:0] py;
        logic               lst;
    } pixel_t;

    pixel_t pixel_queue[$];

    logic               circle_busy;
    logic signed [14:0] circle_cx;
    logic signed [14:0] circle_cy;
    logic signed [14:0] octant_x;
    logic signed [14:0] octant_y;
    logic signed [15:0] x_inc;
    logic signed [15:0] y_inc;
    logic signed [17:0] decision;
    logic signed [15:0] diameter;

    task automatic queue_pixel(input int px, input int py, input logic lst);
        pixel_t p;
        p.px  = px[15:0];
        p.py  = py[15:0];
        p.lst = lst;
        pixel_queue.insert(pixel_queue.size(), p);
    endtask

    task automatic rasterize_request(input logic op_i, input logic signed [14:0] cx_i,
                                     input logic signed [14:0] cy_i, input logic [13:0] r_i);
        int   x;
        int   y;
        int   nx;
        int   ny;
        int   cx;
        int   cy;
        int   e;
        int   xi;
        int   yi;
        int   d;
        logic fin;
        if (op_i == OP_START)
        begin
            d           = int'(r_i) * 2;
            circle_cx   = cx_i;
            circle_cy   = cy_i;
            diameter    = d[15:0];
            octant_x    = 15'(int'(r_i) - 1);
            octant_y    = '0;
            x_inc       = 16'sd1;
            y_inc       = 16'sd1;
            decision    = 18'(1 - d);
            circle_busy = (r_i != 0);
        end
        else if (circle_busy)
        begin
            x  = int'(octant_x);
            y  = int'(octant_y);
            cx = int'(circle_cx);
            cy = int'(circle_cy);
            e  = int'(decision);
            xi = int'(x_inc);
            yi = int'(y_inc);
            d  = int'(diameter);
            nx = x;
            ny = y;
            if (e <= 0)
            begin
                ny = ny + 1;
                e  = e + yi;
                yi = yi + 2;
            end
            if (e > 0)
            begin
                nx = nx - 1;
                xi = xi + 2;
                e  = e + xi - d;
            end
            fin      = (nx < ny);
            octant_x = nx[14:0];
            octant_y = ny[14:0];
            decision = e[17:0];
            x_inc    = xi[15:0];
            y_inc    = yi[15:0];
            if (fin)
                circle_busy = 1'b0;
            queue_pixel(cx + x, cy - y, 1'b0);
            queue_pixel(cx + x, cy + y, 1'b0);
            queue_pixel(cx - x, cy - y, 1'b0);
            queue_pixel(cx - x, cy + y, 1'b0);
            queue_pixel(cx + y, cy - x, 1'b0);
            queue_pixel(cx + y, cy + x, 1'b0);
            queue_pixel(cx - y, cy - x, 1'b0);
            queue_pixel(cx - y, cy + x, fin);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        pixel_t want;
        if (!rst_n)
        begin
            circle_busy    = 1'b0;
            circle_cx      = '0;
            circle_cy      = '0;
            octant_x       = '0;
            octant_y       = '0;
            x_inc          = 16'sd1;
            y_inc          = 16'sd1;
            decision       = '0;
            diameter       = '0;
            pixel_queue.delete();
            fail_count     <= 0;
            pixels_pending <= 0;
            pixels_checked <= 0;
        end
        else
        begin
            if (in_valid && in_ready)
                rasterize_request(op, center_x, center_y, radius);
            if (out_valid && out_ready)
            begin
                if (pixel_queue.size() == 0)
                begin
                    $error("unexpected pixel x=%0d y=%0d last=%0b", point_x, point_y, last);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    want = pixel_queue.pop_front();
                    pixels_checked <= pixels_checked + 1;
                    if (point_x !== want.px || point_y !== want.py || last !== want.lst)
                        fail_count <= fail_count + 1;
                    if (point_x !== want.px)
                        $error("point_x mismatch: expected %0d, actual %0d", want.px, point_x);
                    if (point_y !== want.py)
                        $error("point_y mismatch: expected %0d, actual %0d", want.py, point_y);
                    if (last !== want.lst)
                        $error("last mismatch: expected %0b, actual %0b", want.lst, last);
                end
            end
            pixels_pending <= pixel_queue.size();
        end
    end

endmodule

// File: tb/sv/tb_midpoint_circle_rasterizer_top.sv
// Testbench top: drives circle requests and pixel backpressure, reports the verdict.
module tb_midpoint_circle_rasterizer_top import mcr_pkg::*;;

    localparam int RANDOM_REQUESTS = 108;
    localparam int DRAIN_CYCLES    = 40;
    localparam int LONG_HOLD       = 400;

    logic               clk       = 1'b0;
    logic               rst_n     = 1'b0;
    logic               in_valid  = 1'b0;
    logic               in_ready;
    logic               op        = OP_START;
    logic signed [14:0] center_x  = '0;
    logic signed [14:0] center_y  = '0;
    logic        [13:0] radius    = '0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    logic signed [15:0] point_x;
    logic signed [15:0] point_y;
    logic               last;

    int fail_count;
    int pixels_pending;
    int pixels_checked;
    int requests_sent = 0;
    int starts_sent   = 0;
    logic send_burst  = 1'b0;
    logic recv_burst  = 1'b0;

    midpoint_circle_rasterizer_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .op        (op),
        .center_x  (center_x),
        .center_y  (center_y),
        .radius    (radius),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .point_x   (point_x),
        .point_y   (point_y),
        .last      (last)
    );

    mcr_circle_checker checker_inst (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .op             (op),
        .center_x       (center_x),
        .center_y       (center_y),
        .radius         (radius),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .point_x        (point_x),
        .point_y        (point_y),
        .last           (last),
        .fail_count     (fail_count),
        .pixels_pending (pixels_pending),
        .pixels_checked (pixels_checked)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    task automatic send_request(input logic op_i, input logic signed [14:0] cx_i,
                                input logic signed [14:0] cy_i, input logic [13:0] r_i);
        int gap;
        if ($urandom_range(0, 15) == 0)
            send_burst = !send_burst;
        gap = send_burst ? 0 : $urandom_range(0, 19);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        op       <= op_i;
        center_x <= cx_i;
        center_y <= cy_i;
        radius   <= r_i;
        @(negedge clk);
        while (!in_ready)
            @(negedge clk);
        @(posedge clk);
        requests_sent++;
        if (op_i == OP_START)
            starts_sent++;
    endtask

    task automatic send_step();
        send_request(OP_STEP, 15'($urandom), 15'($urandom), 14'($urandom));
    endtask

    initial
    begin
        int stall;
        int taken;
        logic held;
        taken = 0;
        held  = 1'b0;
        @(posedge rst_n);
        @(posedge clk);
        forever
        begin
            if ($urandom_range(0, 15) == 0)
                recv_burst = !recv_burst;
            stall = recv_burst ? 0 : $urandom_range(0, 19);
            if (!held && taken >= 48)
            begin
                stall = LONG_HOLD;
                held  = 1'b1;
            end
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            @(negedge clk);
            while (!out_valid)
                @(negedge clk);
            @(posedge clk);
            taken++;
        end
    end

    initial
    begin
        int pick;
        int steps;
        int i;
        logic [13:0] r;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_step();
        send_request(OP_START, 15'sd0, 15'sd0, 14'd0);
        send_step();
        send_request(OP_START, 15'sd0, 15'sd0, 14'd1);
        send_step();
        send_step();
        send_request(OP_START, 15'sd16383, 15'sd16383, 14'd2);
        repeat (3) send_step();
        send_request(OP_START, -15'sd16384, -15'sd16384, 14'd3);
        repeat (2) send_step();
        send_request(OP_START, -15'sd16384, 15'sd16383, 14'd16383);
        repeat (2) send_step();
        send_request(OP_START, 15'sd16383, -15'sd16384, 14'd5);
        repeat (5) send_step();

        while (requests_sent < 22 + RANDOM_REQUESTS)
        begin
            pick = $urandom_range(0, 19);
            if (pick == 0)
                r = 14'd0;
            else if (pick <= 2)
                r = 14'($urandom_range(0, 16383));
            else
                r = 14'($urandom_range(1, 12));
            send_request(OP_START, 15'($urandom), 15'($urandom), r);
            if (pick >= 1 && pick <= 2)
                steps = $urandom_range(1, 4);
            else if ($urandom_range(0, 3) == 0)
                steps = $urandom_range(0, int'(r));
            else
                steps = int'(r) * 3 / 4 + 2;
            for (i = 0; i < steps; i++)
                send_step();
        end
        in_valid <= 1'b0;

        @(posedge clk);
        while (pixels_pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d requests (%0d circle starts), compared %0d pixels.",
                 requests_sent, starts_sent, pixels_checked);
        $display("Covered idle steps, empty and extreme circles, restarts, long output stall.");
        if (fail_count == 0 && pixels_pending == 0)
            $display("[midpoint_circle_rasterizer_top] OK");
        else
            $display("[midpoint_circle_rasterizer_top] ERROR");
        $finish;
    end

    initial
    begin
        #(4 * 250000);
        $display("[midpoint_circle_rasterizer_top] ERROR");
        $finish;
    end

endmodule

// File: filelist.f
+incdir+design
design/mcr_pkg.sv
design/mcr_front.sv
design/mcr_queue.sv
design/mcr_back.sv
design/midpoint_circle_rasterizer_top.sv
tb/sv/mcr_circle_checker.sv
tb/sv/tb_midpoint_circle_rasterizer_top.sv
